FILE: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int unsigned DEF_NUM_BLOCKS  = 32768;
    localparam int unsigned DEF_BLOCK_BYTES = 4096;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned BLK_ADDR_W = 27;
    localparam int unsigned FREE_CNT_W = 16;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned MAP_BITS   = 32;
    localparam int unsigned MAP_BIT_W  = 5;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_INIT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic free_chk;
        logic init_wr;
        logic clear_wr;
        logic load_out;
    } t_dp_ctrl;

    typedef struct packed {
        logic in_range;
        logic word_free;
        logic idx_last;
    } t_dp_stat;

endpackage

FILE: rtl/core/bfa_req_if.sv
`timescale 1ns / 1ps
interface bfa_req_if import bfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   free_address;

    modport source (output valid, command, free_address, input ready);
    modport sink   (input valid, command, free_address, output ready);
endinterface

FILE: rtl/core/bfa_rsp_if.sv
`timescale 1ns / 1ps
interface bfa_rsp_if import bfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BLK_ADDR_W-1:0] block_address;
    logic                  out_of_memory;
    logic [FREE_CNT_W-1:0] free_count;

    modport source (output valid, block_address, out_of_memory, free_count, input ready);
    modport sink   (input valid, block_address, out_of_memory, free_count, output ready);
endinterface

FILE: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps
module bfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bfa_ctrl.sv
`timescale 1ns / 1ps
module bfa_ctrl import bfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    input  t_dp_stat         i_stat,
    output t_dp_ctrl         o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        o_req_ready = 1'b0;
        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                o_ctrl.clear_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctrl.accept = 1'b1;
                    unique case (t_cmd'(i_command))
                        CMD_ALLOC: n_state = ST_SCAN;
                        CMD_FREE:  n_state = i_stat.in_range ? ST_FREE : ST_RESP;
                        CMD_INIT:  n_state = ST_INIT;
                        CMD_NOP:   n_state = ST_RESP;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctrl.scan = 1'b1;
                if (i_stat.word_free || i_stat.idx_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_FREE: begin
                o_ctrl.free_chk = 1'b1;
                n_state         = ST_RESP;
            end
            ST_INIT: begin
                o_ctrl.init_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_ctrl.load_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_rsp_valid = r_out_valid;

endmodule

FILE: rtl/core/bfa_datapath.sv
`timescale 1ns / 1ps
module bfa_datapath import bfa_pkg::*; #(
    parameter int unsigned NUM_BLOCKS  = DEF_NUM_BLOCKS,
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctrl              i_ctrl,
    output t_dp_stat              o_stat,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [ADDR_W-1:0]     i_free_address,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_wdata,
    output logic [BLK_ADDR_W-1:0] o_block_address,
    output logic                  o_out_of_memory,
    output logic [FREE_CNT_W-1:0] o_free_count
);

    localparam int unsigned BLK_SH    = $clog2(BLOCK_BYTES);
    localparam int unsigned MAP_WORDS = (NUM_BLOCKS + MAP_BITS - 1) / MAP_BITS;
    localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned LO_W      = ADDR_W - BLK_SH + 1;
    localparam int unsigned BI_W      = (LO_W > WA_W + MAP_BIT_W + 1) ? LO_W
                                        : (WA_W + MAP_BIT_W + 1);
    localparam int unsigned WI_W      = BI_W - MAP_BIT_W;
    localparam int unsigned EXT_W     = WA_W + MAP_BIT_W + BLK_SH + BLK_ADDR_W;
    localparam int unsigned TAIL_BITS = NUM_BLOCKS % MAP_BITS;

    localparam logic [MAP_BITS-1:0] ONES     = 32'hFFFF_FFFF;
    localparam logic [MAP_BITS-1:0] PAD_MASK = (TAIL_BITS == 0) ? '0
                                               : ~((32'h1 << TAIL_BITS) - 32'h1);
    localparam logic [WA_W-1:0]     LAST_WORD = WA_W'(MAP_WORDS - 1);
    localparam logic [BI_W-1:0]     TOTAL_BI  = BI_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]    TOTAL_CNT = CNT_W'(NUM_BLOCKS);

    function automatic logic [MAP_BIT_W-1:0] first_zero(input logic [MAP_BITS-1:0] w);
        logic [MAP_BIT_W-1:0] pos;
        pos = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = MAP_BIT_W'(i);
            end
        end
        return pos;
    endfunction

    logic [ADDR_W-1:0]     r_memory_size;
    logic [ADDR_W-1:0]     r_reserved_end;
    logic [WA_W-1:0]       r_idx;
    logic [CNT_W-1:0]      r_used;
    logic [MAP_BIT_W-1:0]  r_bit;
    logic [BI_W-1:0]       r_lo;
    logic [BI_W-1:0]       r_hi;
    logic [BLK_ADDR_W-1:0] r_res_addr;
    logic                  r_res_oom;
    logic [BLK_ADDR_W-1:0] r_out_addr;
    logic                  r_out_oom;
    logic [FREE_CNT_W-1:0] r_out_free;

    logic [MAP_BITS-1:0]   rd_data;
    logic [MAP_BITS-1:0]   scan_word;
    logic [MAP_BIT_W-1:0]  zero_pos;
    logic                  idx_last;
    logic                  word_free;
    logic                  bit_used;
    logic [BI_W-1:0]       in_blk;
    logic [WA_W-1:0]       idx_start;
    logic [WA_W-1:0]       rd_addr;
    logic                  wr_en;
    logic [MAP_BITS-1:0]   wr_data;
    logic [LO_W-1:0]       lo_n;
    logic [BI_W-1:0]       hi_raw;
    logic [BI_W-1:0]       hi_n;
    logic [WI_W-1:0]       idx_x;
    logic [MAP_BITS-1:0]   low_m;
    logic [MAP_BITS-1:0]   high_m;
    logic [MAP_BITS-1:0]   init_free;
    logic [BI_W-1:0]       span;
    logic [CNT_W-1:0]      init_used;
    logic [EXT_W-1:0]      blk_ext;
    logic [CNT_W-1:0]      free_n;

    assign idx_last  = (r_idx == LAST_WORD);
    assign scan_word = rd_data | (idx_last ? PAD_MASK : '0);
    assign word_free = ~&scan_word;
    assign zero_pos  = first_zero(scan_word);
    assign bit_used  = rd_data[r_bit];

    assign in_blk    = BI_W'(i_free_address >> BLK_SH);
    assign idx_start = (t_cmd'(i_command) == CMD_FREE)
                       ? in_blk[WA_W+MAP_BIT_W-1:MAP_BIT_W] : '0;
    assign rd_addr   = (i_ctrl.scan && !idx_last) ? r_idx + WA_W'(1) : idx_start;

    assign o_stat.in_range  = (in_blk < TOTAL_BI);
    assign o_stat.word_free = word_free;
    assign o_stat.idx_last  = idx_last;

    // init range in blocks: ceil(reserved_end / block) .. min(memory_size / block, total)
    assign lo_n   = LO_W'(r_reserved_end >> BLK_SH)
                  + LO_W'(r_reserved_end[BLK_SH-1:0] != '0);
    assign hi_raw = BI_W'(r_memory_size >> BLK_SH);
    assign hi_n   = (hi_raw > TOTAL_BI) ? TOTAL_BI : hi_raw;

    assign idx_x  = WI_W'(r_idx);
    assign low_m  = (idx_x < r_lo[BI_W-1:MAP_BIT_W]) ? '0
                  : (idx_x == r_lo[BI_W-1:MAP_BIT_W]) ? (ONES << r_lo[MAP_BIT_W-1:0])
                  : ONES;
    assign high_m = (idx_x < r_hi[BI_W-1:MAP_BIT_W]) ? ONES
                  : (idx_x == r_hi[BI_W-1:MAP_BIT_W]) ? ~(ONES << r_hi[MAP_BIT_W-1:0])
                  : '0;
    assign init_free = low_m & high_m;
    assign span      = (r_hi > r_lo) ? (r_hi - r_lo) : '0;
    assign init_used = CNT_W'(TOTAL_BI - span);

    assign blk_ext = EXT_W'({r_idx, zero_pos}) << BLK_SH;
    assign free_n  = TOTAL_CNT - r_used;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        if (i_ctrl.clear_wr) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
        if (i_ctrl.init_wr) begin
            wr_en   = 1'b1;
            wr_data = ~init_free;
        end
        if (i_ctrl.scan && word_free) begin
            wr_en   = 1'b1;
            wr_data = rd_data | (32'h1 << zero_pos);
        end
        if (i_ctrl.free_chk && bit_used) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~(32'h1 << r_bit);
        end
    end

    bfa_ram #(
        .WIDTH (MAP_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_size  <= '0;
            r_reserved_end <= '0;
            r_idx          <= '0;
            r_used         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MEMORY_SIZE:  r_memory_size  <= i_cfg_wdata;
                    CFG_RESERVED_END: r_reserved_end <= i_cfg_wdata;
                endcase
            end
            if (i_ctrl.accept) begin
                r_idx <= idx_start;
            end
            if ((i_ctrl.clear_wr || i_ctrl.init_wr) && !idx_last) begin
                r_idx <= r_idx + WA_W'(1);
            end
            if (i_ctrl.scan && !word_free && !idx_last) begin
                r_idx <= r_idx + WA_W'(1);
            end
            if (i_ctrl.scan && word_free) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_ctrl.free_chk && bit_used) begin
                r_used <= r_used - CNT_W'(1);
            end
            if (i_ctrl.init_wr && idx_last) begin
                r_used <= init_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_bit      <= in_blk[MAP_BIT_W-1:0];
            r_res_addr <= '0;
            r_res_oom  <= 1'b0;
            r_lo       <= BI_W'(lo_n);
            r_hi       <= hi_n;
        end
        if (i_ctrl.scan) begin
            if (word_free) begin
                r_res_addr <= blk_ext[BLK_ADDR_W-1:0];
            end else if (idx_last) begin
                r_res_oom <= 1'b1;
            end
        end
        if (i_ctrl.load_out) begin
            r_out_addr <= r_res_addr;
            r_out_oom  <= r_res_oom;
            r_out_free <= FREE_CNT_W'(free_n);
        end
    end

    assign o_block_address = r_out_addr;
    assign o_out_of_memory = r_out_oom;
    assign o_free_count    = r_out_free;

endmodule

FILE: rtl/core/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit page frame allocator over a usage bitmap held in a RAM of
// ceil(NUM_BLOCKS/32) words, one bit per block, 1 meaning used. Each request
// yields one response with the free block count after the request. An alloc
// scans the bitmap from word 0, one word per cycle through the RAM read port,
// until it finds a word with a free block or reaches the last word when memory
// is full. A free of an in-range address reads, modify-writes and then
// responds; one out of range responds without touching the bitmap. An init
// rewrites every word, and a NOP command only responds. After reset the
// bitmap is cleared by a pass over all ceil(NUM_BLOCKS/32) words (1024 at the
// default size) during which no request is taken; configuration writes are
// accepted at any time.
// BLOCK_BYTES must be a power of two. A finished response waits in an output
// register while the next request is taken.
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
    parameter int unsigned NUM_BLOCKS  = DEF_NUM_BLOCKS,
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfa_req_if.sink              i_req,
    bfa_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_wdata
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_command   (i_req.command),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl)
    );

    bfa_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (dp_ctrl),
        .o_stat          (dp_stat),
        .i_command       (i_req.command),
        .i_free_address  (i_req.free_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_block_address (o_rsp.block_address),
        .o_out_of_memory (o_rsp.out_of_memory),
        .o_free_count    (o_rsp.free_count)
    );

`ifndef NO_ASSERTIONS
    a_oom_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.out_of_memory) |-> (o_rsp.block_address == '0))
        else $error("out of memory response carries a block address");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in progress");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request taken before bitmap clear finished");
`endif

endmodule
